### rtl/core/msto_pkg.sv
`timescale 1ns / 1ps

package msto_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int TIME_BITS  = 32;
	localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);

	typedef logic [TIME_BITS-1:0] time_t;

	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_SET   = 2'd1;
	localparam logic [1:0] FN_UNSET = 2'd2;
	localparam logic [1:0] FN_QUERY = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_PASSED = 2'd1;
	localparam logic [1:0] ST_UNUSED = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	// Write strobes from the control logic into one cell.
	typedef struct packed {
		logic tick;
		logic set_en;
		logic clr_en;
	} cell_cmd_t;

	// Flags that one cell shows to the control logic.
	typedef struct packed {
		logic in_use;
		logic armed;
		logic expired;
	} cell_stat_t;

	// Running minimum handed from cell to cell.
	typedef struct packed {
		logic  found;
		time_t best;
	} chain_t;

	function automatic time_t sat_time(input logic [31:0] d);
		logic [TIME_BITS+31:0] w;
		logic [TIME_BITS+31:0] lim;
		w   = {{TIME_BITS{1'b0}}, d};
		lim = {32'd0, {TIME_BITS{1'b1}}};
		if (w > lim) begin
			return {TIME_BITS{1'b1}};
		end
		return w[TIME_BITS-1:0];
	endfunction

	function automatic logic [31:0] sat_delay(input time_t r);
		logic [TIME_BITS+31:0] w;
		logic [TIME_BITS+31:0] lim;
		w   = {32'd0, r};
		lim = {{TIME_BITS{1'b0}}, 32'hFFFF_FFFF};
		if (w > lim) begin
			return 32'hFFFF_FFFF;
		end
		return w[31:0];
	endfunction

endpackage

### rtl/core/msto_cell.sv
`timescale 1ns / 1ps

module msto_cell import msto_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  time_t      now_q,
	input  time_t      now_next,
	input  time_t      deadline_new,
	input  chain_t     chain_in,
	output chain_t     chain_out,
	output cell_stat_t stat,
	output logic       hit
);

	logic  in_use_q;
	logic  armed_q;
	logic  expired_q;
	time_t deadline_q;
	chain_t chain_q;
	logic  pending;
	time_t rem;

	assign pending = in_use_q & armed_q & ~expired_q;
	assign rem     = deadline_q - now_q;
	assign hit     = cmd.tick & pending & (deadline_q == now_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= 1'b0;
			armed_q   <= 1'b0;
			expired_q <= 1'b0;
		end else begin
			if (cmd.set_en) begin
				in_use_q  <= 1'b1;
				armed_q   <= 1'b1;
				expired_q <= 1'b0;
			end else if (cmd.clr_en) begin
				in_use_q  <= 1'b0;
				armed_q   <= 1'b0;
				expired_q <= 1'b0;
			end else if (hit) begin
				expired_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_en) begin
			deadline_q <= deadline_new;
		end
	end

	// The minimum ripples one cell per cycle; each cell folds in its own remaining time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else begin
			if (pending && (!chain_in.found || rem < chain_in.best)) begin
				chain_q.found <= 1'b1;
				chain_q.best  <= rem;
			end else begin
				chain_q.found <= chain_in.found | pending;
				chain_q.best  <= chain_in.best;
			end
		end
	end

	assign chain_out    = chain_q;
	assign stat.in_use  = in_use_q;
	assign stat.armed   = armed_q;
	assign stat.expired = expired_q;

endmodule

### rtl/core/multi_slot_timeout_unit.sv
`timescale 1ns / 1ps
// One word at a time: in_ready drops on acceptance and rises once the result is loaded
// into the output register, which waits while out_ready is low. The minimum-deadline
// search ripples through the row of slot cells one cell per cycle before that load.
// Reset (arst_n low, asynchronous) clears the tick count, every slot's flags, the search
// chain and the result valid flag; deadlines and result fields hold no value until written.

module multi_slot_timeout_unit import msto_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [3:0]  slot_sel,
	input  logic [31:0] duration,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  slot_out,
	output logic [15:0] expired_mask,
	output logic [31:0] next_delay,
	output logic        next_valid
);

	time_t               now_q;
	time_t               now_next;
	time_t               deadline_new;
	cell_cmd_t           cmd   [SLOT_COUNT];
	cell_stat_t          stat  [SLOT_COUNT];
	chain_t              link  [SLOT_COUNT+1];
	logic [SLOT_COUNT-1:0] hit;
	logic [SLOT_COUNT-1:0] free;
	logic [SLOT_COUNT-1:0] grant;
	logic [SLOT_COUNT-1:0] exp_vec;
	logic [SLOT_COUNT-1:0] arm_vec;
	logic [SLOT_BITS-1:0]  grant_idx;
	logic [SLOT_BITS+3:0]  sel_w;
	logic [SLOT_BITS+3:0]  grant_w;
	logic [SLOT_COUNT+15:0] hit_w;
	logic [SLOT_BITS-1:0]  sel_idx;
	logic                  sel_ok;
	logic                  sel_used;
	logic                  set_ok;
	logic                  in_fire;
	logic                  load_out;
	logic                  busy_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [1:0]            status_q;
	logic [3:0]            slot_q;
	logic [15:0]           mask_q;
	logic [1:0]            status_d;
	logic [3:0]            slot_d;
	logic [15:0]           mask_d;
	logic                  out_valid_q;
	logic [1:0]            status_out_q;
	logic [3:0]            slot_out_q;
	logic [15:0]           mask_out_q;
	logic [31:0]           delay_out_q;
	logic                  nvalid_out_q;

	assign in_ready = ~busy_q;
	assign in_fire  = in_valid & in_ready;
	assign load_out = busy_q && (cnt_q == '0) && (!out_valid_q || out_ready);

	assign now_next     = now_q + time_t'(1);
	assign deadline_new = now_q + sat_time(duration);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			free[i]    = ~stat[i].in_use;
			exp_vec[i] = stat[i].expired;
			arm_vec[i] = stat[i].armed & stat[i].in_use;
		end
	end

	// Lowest free slot as a one-hot word.
	assign grant = free & (~free + SLOT_COUNT'(1));

	always_comb begin
		grant_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (grant[i]) begin
				grant_idx = grant_idx | SLOT_BITS'(i);
			end
		end
	end

	assign set_ok  = (|free) && (duration != 32'd0);
	assign sel_w   = (SLOT_BITS+4)'(slot_sel);
	assign sel_ok  = sel_w < (SLOT_BITS+4)'(SLOT_COUNT);
	assign sel_idx = sel_w[SLOT_BITS-1:0];
	assign sel_used = sel_ok && stat[sel_idx].in_use && stat[sel_idx].armed;
	assign grant_w = (SLOT_BITS+4)'(grant_idx);
	assign hit_w   = (SLOT_COUNT+16)'(hit);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			cmd[i].tick   = in_fire && (func == FN_TICK);
			cmd[i].set_en = in_fire && (func == FN_SET) && set_ok && grant[i];
			cmd[i].clr_en = in_fire && (func == FN_UNSET) && sel_used
				&& (sel_idx == SLOT_BITS'(i));
		end
	end

	always_comb begin
		status_d = ST_OK;
		slot_d   = 4'd0;
		mask_d   = 16'd0;
		unique case (func)
			FN_TICK: begin
				mask_d = hit_w[15:0];
			end
			FN_SET: begin
				if (set_ok) begin
					slot_d = grant_w[3:0];
				end else begin
					status_d = ST_REJECT;
				end
			end
			FN_UNSET, FN_QUERY: begin
				if (!sel_used) begin
					status_d = ST_UNUSED;
				end else if (stat[sel_idx].expired) begin
					status_d = ST_PASSED;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign link[0] = '0;

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		msto_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd[g]),
			.now_q        (now_q),
			.now_next     (now_next),
			.deadline_new (deadline_new),
			.chain_in     (link[g]),
			.chain_out    (link[g+1]),
			.stat         (stat[g]),
			.hit          (hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_fire && (func == FN_TICK)) begin
				now_q <= now_next;
			end
			if (in_fire) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(SLOT_COUNT);
			end else if (load_out) begin
				busy_q <= 1'b0;
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			mask_q   <= mask_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_out_q <= status_q;
			slot_out_q   <= slot_q;
			mask_out_q   <= mask_q;
			delay_out_q  <= link[SLOT_COUNT].found ? sat_delay(link[SLOT_COUNT].best) : 32'd0;
			nvalid_out_q <= link[SLOT_COUNT].found;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_out_q;
	assign slot_out     = slot_out_q;
	assign expired_mask = mask_out_q;
	assign next_delay   = delay_out_q;
	assign next_valid   = nvalid_out_q;

	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_q && (cnt_q == CNT_BITS'(SLOT_COUNT)))
		else $error("search count not started on accepted word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant))
		else $error("more than one slot granted");

	a_expired_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_vec & ~arm_vec) == '0)
		else $error("passed mark on a slot that is not armed");

endmodule
